/* rtl/core/nwr_pkg.sv */
`timescale 1ns / 1ps
package nwr_pkg;

  localparam int PATTERNS_DEF    = 8;
  localparam int MAX_PREFIX_DEF  = 64;
  localparam int MAX_WEIGHTS_DEF = 16;
  localparam int MAX_REPLIES_DEF = 8;

  localparam logic [31:0] PCG_MUL_LO = 32'h4C957F2D;
  localparam logic [31:0] PCG_MUL_HI = 32'h5851F42D;
  localparam int RND_BITS = 32;

  typedef enum logic [2:0] {
    CMD_PREFIX = 3'd0,
    CMD_PLEN   = 3'd1,
    CMD_WEIGHT = 3'd2,
    CMD_WCOUNT = 3'd3,
    CMD_REPLY  = 3'd4,
    CMD_NAME   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_PATTERN_COUNT  = 3'd0,
    REG_NACK_UNMATCHED = 3'd1,
    REG_NO_ROUTE       = 3'd2,
    REG_RNG_SEED       = 3'd3,
    REG_RNG_STREAM     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_DATA = 2'd0,
    ACT_NACK = 2'd1,
    ACT_DROP = 2'd2
  } act_t;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_NACK = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_ADV,
    S_DIV, S_WRD, S_RRD, S_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  pattern_sel;
    logic [5:0]  slot;
    logic [9:0]  value;
    logic        last;
    logic [63:0] token;
  } item_t;

  typedef struct packed {
    logic        matched;
    logic [2:0]  pattern_index;
    logic [2:0]  reply_index;
    logic [1:0]  action;
    logic [7:0]  nack_code;
    logic [63:0] token_out;
  } result_t;

endpackage

/* rtl/core/name_prefix_weighted_responder_top.sv */
`timescale 1ns / 1ps
// Load and config transactions leave busy low. Name byte: busy after accept, one pattern
// compared per prefix read. Last byte, unmatched: result in the cycle after the last compare.
// Matched: busy on through the state multiply from partial products of the shared 32x32
// multiplier, the state add, a bit-serial remainder, two table reads and a finish state.
// done is high one cycle; no receiver stall. Synchronous active-high rst resets control,
// flop tables, config and rng state; the memories get no clearing pass.
module name_prefix_weighted_responder_top
  import nwr_pkg::*;
#(
  parameter int PATTERNS    = PATTERNS_DEF,
  parameter int MAX_PREFIX  = MAX_PREFIX_DEF,
  parameter int MAX_WEIGHTS = MAX_WEIGHTS_DEF,
  parameter int MAX_REPLIES = MAX_REPLIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        done,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int PW  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int LW  = $clog2(MAX_PREFIX + 1);
  localparam int CW  = $clog2(MAX_WEIGHTS + 1);
  localparam int PD  = PATTERNS * MAX_PREFIX;
  localparam int WD  = PATTERNS * MAX_WEIGHTS;
  localparam int RD  = PATTERNS * MAX_REPLIES;
  localparam int PA  = (PD > 1) ? $clog2(PD) : 1;
  localparam int WA  = (WD > 1) ? $clog2(WD) : 1;
  localparam int RA  = (RD > 1) ? $clog2(RD) : 1;
  localparam int DCW = $clog2(RND_BITS);

  state_t state, state_next;

  // config
  logic [3:0]  pattern_count;
  logic        nack_unmatched;
  logic [7:0]  no_route_reason;
  logic [62:0] rng_stream;
  logic [63:0] rng_state;

  // tables in flops
  logic [LW-1:0] plen [PATTERNS];
  logic [CW-1:0] wcount [PATTERNS];
  logic          flags [PATTERNS];
  logic [LW-1:0] name_length;

  // memories
  logic [7:0] prefix_mem [PD];
  logic [2:0] weight_mem [WD];
  logic [1:0] kind_mem [RD];
  logic [7:0] reason_mem [RD];
  logic [7:0] prefix_q;
  logic [2:0] weight_q;
  logic [1:0] kind_q;
  logic [7:0] reason_q;

  // working registers
  logic [PW-1:0]  p;
  logic           found;
  logic [PW-1:0]  found_p;
  logic [7:0]     name_byte;
  logic           is_last;
  logic [63:0]    token_q;
  logic [63:0]    prod;
  logic [63:0]    acc;
  logic [31:0]    rnd;
  logic [CW-1:0]  rem;
  logic [CW-1:0]  cnt;
  logic [DCW-1:0] div_cnt;
  logic [2:0]     ri;

  logic          accept;
  logic          sel_ok;
  logic [PA-1:0] p_waddr, p_raddr;
  logic [WA-1:0] w_waddr, w_raddr;
  logic [RA-1:0] r_waddr, r_raddr;
  logic [LW-1:0] pos, new_len;
  logic [2:0]    wval;
  logic          flag_new;
  logic [31:0]   mul_a, mul_b;
  logic [31:0]   xs;
  logic [4:0]    rot;
  logic [CW:0]   trial;

  assign accept = start && !busy;
  assign sel_ok = 32'(item.pattern_sel) < PATTERNS;

  assign pos     = (32'(name_length) < MAX_PREFIX) ? name_length : LW'(MAX_PREFIX - 1);
  assign new_len = (32'(name_length) < MAX_PREFIX) ? name_length + LW'(1) : name_length;
  assign flag_new = flags[p] &&
                    !((name_length < plen[p]) && (prefix_q != name_byte));

  assign p_waddr = PA'(32'(item.pattern_sel) * MAX_PREFIX + 32'(item.slot));
  assign w_waddr = WA'(32'(item.pattern_sel) * MAX_WEIGHTS + 32'(item.slot));
  assign r_waddr = RA'(32'(item.pattern_sel) * MAX_REPLIES + 32'(item.slot));
  assign p_raddr = PA'(32'(p) * MAX_PREFIX + 32'(pos));
  assign w_raddr = WA'(32'(found_p) * MAX_WEIGHTS + 32'(rem));
  assign r_raddr = RA'(32'(found_p) * MAX_REPLIES + 32'(weight_q));

  assign wval = (32'(item.value[2:0]) >= MAX_REPLIES) ? 3'(MAX_REPLIES - 1)
                                                     : item.value[2:0];

  // PCG output permutation from the old state
  assign xs  = 32'((rng_state ^ (rng_state >> 18)) >> 27);
  assign rot = rng_state[63:59];

  assign trial = {rem, rnd[31]};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && item.cmd == CMD_NAME) state_next = S_RD;
      S_RD:   state_next = S_CMP;
      S_CMP: begin
        if (32'(p) != PATTERNS - 1) state_next = S_RD;
        else if (!is_last) state_next = S_IDLE;
        else if (found || (flag_new && 32'(p) < 32'(pattern_count) &&
                           plen[p] <= new_len)) state_next = S_MUL0;
        else state_next = S_IDLE;
      end
      S_MUL0: state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = S_ADV;
      S_ADV:  state_next = S_DIV;
      S_DIV:  if (div_cnt == DCW'(RND_BITS - 1)) state_next = S_WRD;
      S_WRD:  state_next = S_RRD;
      S_RRD:  state_next = S_FIN;
      S_FIN:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer: busy and multiplier operand select
  always_comb begin
    busy  = (state != S_IDLE);
    mul_a = rng_state[31:0];
    mul_b = PCG_MUL_LO;
    unique case (state)
      S_MUL1: mul_b = PCG_MUL_HI;
      S_MUL2: mul_a = rng_state[63:32];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept && sel_ok) begin
      if (item.cmd == CMD_PREFIX && 32'(item.slot) < MAX_PREFIX)
        prefix_mem[p_waddr] <= item.value[7:0];
      if (item.cmd == CMD_WEIGHT && 32'(item.slot) < MAX_WEIGHTS)
        weight_mem[w_waddr] <= wval;
      if (item.cmd == CMD_REPLY && 32'(item.slot) < MAX_REPLIES) begin
        kind_mem[r_waddr]   <= item.value[9:8];
        reason_mem[r_waddr] <= item.value[7:0];
      end
    end
    prefix_q <= prefix_mem[p_raddr];
    weight_q <= weight_mem[w_raddr];
    kind_q   <= kind_mem[r_raddr];
    reason_q <= reason_mem[r_raddr];
  end

  // control, tables and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count   <= '0;
      nack_unmatched  <= 1'b0;
      no_route_reason <= 8'd150;
      rng_stream      <= '0;
      rng_state       <= '0;
      name_length     <= '0;
      done            <= 1'b0;
      found           <= 1'b0;
      p               <= '0;
      for (int i = 0; i < PATTERNS; i++) begin
        plen[i]   <= '0;
        wcount[i] <= '0;
        flags[i]  <= 1'b1;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PATTERN_COUNT:  pattern_count   <= cfg_data[3:0];
          REG_NACK_UNMATCHED: nack_unmatched  <= cfg_data[0];
          REG_NO_ROUTE:       no_route_reason <= cfg_data[7:0];
          REG_RNG_SEED:       rng_state       <= cfg_data;
          REG_RNG_STREAM:     rng_stream      <= cfg_data[62:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (accept && sel_ok && item.cmd == CMD_PLEN)
            plen[item.pattern_sel[PW-1:0]] <= (32'(item.value) > MAX_PREFIX) ?
                LW'(MAX_PREFIX) : LW'(item.value);
          if (accept && sel_ok && item.cmd == CMD_WCOUNT)
            wcount[item.pattern_sel[PW-1:0]] <= (32'(item.value) > MAX_WEIGHTS) ?
                CW'(MAX_WEIGHTS) : CW'(item.value);
          if (accept && item.cmd == CMD_NAME) begin
            name_byte <= item.value[7:0];
            is_last   <= item.last;
            token_q   <= item.token;
            p         <= '0;
            found     <= 1'b0;
          end
        end
        S_CMP: begin
          if (!(is_last && 32'(p) == PATTERNS - 1)) flags[p] <= flag_new;
          if (!found && flag_new && 32'(p) < 32'(pattern_count) &&
              plen[p] <= new_len) begin
            found   <= 1'b1;
            found_p <= p;
          end
          if (32'(p) != PATTERNS - 1) begin
            p <= p + PW'(1);
          end else begin
            name_length <= is_last ? '0 : new_len;
            if (is_last) begin
              for (int i = 0; i < PATTERNS; i++) flags[i] <= 1'b1;
              if (!(found || (flag_new && 32'(p) < 32'(pattern_count) &&
                              plen[p] <= new_len))) begin
                done                 <= 1'b1;
                result.matched       <= 1'b0;
                result.pattern_index <= '0;
                result.reply_index   <= '0;
                result.action        <= nack_unmatched ? ACT_NACK : ACT_DROP;
                result.nack_code     <= nack_unmatched ? no_route_reason : 8'd0;
                result.token_out     <= token_q;
              end
            end
          end
        end
        S_MUL0: begin
          prod    <= 64'(mul_a) * 64'(mul_b);
          rnd     <= (xs >> rot) | (xs << ((5'd0 - rot) & 5'd31));
          rem     <= '0;
          div_cnt <= '0;
          cnt     <= (wcount[found_p] == '0) ? CW'(1) : wcount[found_p];
        end
        S_MUL1: begin
          acc  <= prod;
          prod <= 64'(mul_a) * 64'(mul_b);
        end
        S_MUL2: begin
          acc  <= acc + {prod[31:0], 32'd0};
          prod <= 64'(mul_a) * 64'(mul_b);
        end
        S_MUL3: acc <= acc + {prod[31:0], 32'd0};
        S_ADV:  rng_state <= acc + {rng_stream, 1'b1};
        S_DIV: begin
          // restoring remainder, one bit of rnd per cycle
          rem     <= (trial >= {1'b0, cnt}) ? CW'(trial - {1'b0, cnt}) : trial[CW-1:0];
          rnd     <= {rnd[30:0], 1'b0};
          div_cnt <= div_cnt + DCW'(1);
        end
        S_RRD: ri <= weight_q;
        S_FIN: begin
          done                 <= 1'b1;
          result.matched       <= 1'b1;
          result.pattern_index <= 3'(found_p);
          result.reply_index   <= ri;
          result.token_out     <= token_q;
          if (kind_q == KIND_DATA) begin
            result.action    <= ACT_DATA;
            result.nack_code <= 8'd0;
          end else if (kind_q == KIND_NACK) begin
            result.action    <= ACT_NACK;
            result.nack_code <= reason_q;
          end else begin
            result.action    <= ACT_DROP;
            result.nack_code <= 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/nwr_chk.sv */
`timescale 1ns / 1ps
module nwr_chk
  import nwr_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    done,
  input result_t result
);

  // loads finish in the cycle they are taken
  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd != CMD_NAME) |=> !busy)
    else $error("load transaction left the block busy");

  // a result only follows work on a name
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result without a preceding name transaction");

  a_no_match_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !result.matched) |->
      (result.pattern_index == 3'd0 && result.reply_index == 3'd0 &&
       (result.action == ACT_NACK || result.action == ACT_DROP)))
    else $error("unmatched result carries pattern fields");

  a_nack_code: assert property (@(posedge clk) disable iff (rst)
    (done && result.action != ACT_NACK) |-> result.nack_code == 8'd0)
    else $error("nack code set without nack");

endmodule

bind name_prefix_weighted_responder_top nwr_chk u_nwr_chk (.*);

/* dv/name_prefix_weighted_responder_top_test.sv */
`timescale 1ns / 1ps
module name_prefix_weighted_responder_top_test;
  import nwr_pkg::*;

  localparam int NPAT = 8;
  localparam int NPFX = 64;
  localparam int NWGT = 16;
  localparam int NREP = 8;
  localparam int PFX_FILL = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS = 45;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item;
  logic        done;
  result_t     result;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  // typed-in expectation travels with the item it belongs to
  logic        typed_valid;
  result_t     typed_res;

  name_prefix_weighted_responder_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // responder mirror
  logic [7:0]  pfx_mem [NPAT][NPFX];
  logic [6:0]  plen_tbl [NPAT];
  logic [2:0]  wgt_mem [NPAT][NWGT];
  logic [4:0]  wcnt_tbl [NPAT];
  logic [1:0]  rkind_mem [NPAT][NREP];
  logic [7:0]  rreason_mem [NPAT][NREP];
  bit          still_match [NPAT];
  int          name_len;
  logic [63:0] rng_st;
  logic [3:0]  pat_count;
  logic        nack_unm;
  logic [7:0]  noroute_code;
  logic [62:0] rng_stream;

  result_t     pending_replies[$];
  int          errors;
  int          idle_cycles;
  int          idle_pct;
  int          sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] pcg_next();
    logic [63:0] old;
    logic [31:0] xs;
    int          rot;
    old = rng_st;
    rng_st = old * 64'h5851F42D4C957F2D + {rng_stream, 1'b1};
    xs = 32'((((old >> 18) ^ old) >> 27));
    rot = int'(old[63:59]);
    return (xs >> rot) | (xs << ((32 - rot) & 31));
  endfunction

  task automatic clear_name();
    for (int p = 0; p < NPAT; p++) still_match[p] = 1'b1;
    name_len = 0;
  endtask

  task automatic predict_item(input item_t it, output bit has, output result_t r);
    int          hit;
    int          lim;
    int          cnt;
    logic [31:0] rnd;
    logic [2:0]  ri;
    has = 1'b0;
    r = '0;
    hit = -1;
    case (it.cmd)
      CMD_PREFIX: if (it.slot < NPFX) pfx_mem[it.pattern_sel][it.slot] = it.value[7:0];
      CMD_PLEN: plen_tbl[it.pattern_sel] = (it.value > NPFX) ? 7'(NPFX) : 7'(it.value);
      CMD_WEIGHT: if (it.slot < NWGT) wgt_mem[it.pattern_sel][it.slot] = it.value[2:0];
      CMD_WCOUNT: wcnt_tbl[it.pattern_sel] = (it.value > NWGT) ? 5'(NWGT) : 5'(it.value);
      CMD_REPLY: begin
        if (it.slot < NREP) begin
          rkind_mem[it.pattern_sel][it.slot] = it.value[9:8];
          rreason_mem[it.pattern_sel][it.slot] = it.value[7:0];
        end
      end
      CMD_NAME: begin
        for (int p = 0; p < NPAT; p++)
          if (name_len < plen_tbl[p] && pfx_mem[p][name_len] != it.value[7:0])
            still_match[p] = 1'b0;
        if (name_len < NPFX) name_len++;
        if (it.last) begin
          has = 1'b1;
          lim = (pat_count > NPAT) ? NPAT : pat_count;
          for (int p = 0; p < lim; p++)
            if (hit < 0 && still_match[p] && plen_tbl[p] <= name_len) hit = p;
          r.token_out = it.token;
          if (hit < 0) begin
            r.action = nack_unm ? ACT_NACK : ACT_DROP;
            r.nack_code = nack_unm ? noroute_code : 8'd0;
          end else begin
            cnt = (wcnt_tbl[hit] == 0) ? 1 : wcnt_tbl[hit];
            rnd = pcg_next();
            ri = wgt_mem[hit][rnd % cnt];
            r.matched = 1'b1;
            r.pattern_index = 3'(hit);
            r.reply_index = ri;
            case (rkind_mem[hit][ri])
              KIND_DATA: r.action = ACT_DATA;
              KIND_NACK: begin
                r.action = ACT_NACK;
                r.nack_code = rreason_mem[hit][ri];
              end
              default: r.action = ACT_DROP;
            endcase
          end
          clear_name();
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_reply(input result_t got);
    result_t want;
    if (pending_replies.size() == 0) begin
      $display("%0t: unexpected reply %p", $time, got);
      errors++;
    end else begin
      want = pending_replies.pop_front();
      if (got.matched !== want.matched)
        $display("%0t: matched exp %0d got %0d", $time, want.matched, got.matched);
      if (got.pattern_index !== want.pattern_index)
        $display("%0t: pattern_index exp %0d got %0d", $time, want.pattern_index,
                 got.pattern_index);
      if (got.reply_index !== want.reply_index)
        $display("%0t: reply_index exp %0d got %0d", $time, want.reply_index,
                 got.reply_index);
      if (got.action !== want.action)
        $display("%0t: action exp %0d got %0d", $time, want.action, got.action);
      if (got.nack_code !== want.nack_code)
        $display("%0t: nack_code exp %0d got %0d", $time, want.nack_code, got.nack_code);
      if (got.token_out !== want.token_out)
        $display("%0t: token_out exp %h got %h", $time, want.token_out, got.token_out);
      if (got !== want) errors++;
    end
  endtask

  always @(posedge clk) begin
    bit      has;
    result_t r;
    if (rst) begin
      for (int p = 0; p < NPAT; p++) begin
        plen_tbl[p] = '0;
        wcnt_tbl[p] = '0;
      end
      clear_name();
      pat_count = '0;
      nack_unm = 1'b0;
      noroute_code = 8'd150;
      rng_stream = '0;
      rng_st = '0;
      idle_cycles = 0;
    end else begin
      if (done) check_reply(result);
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_COUNT:  pat_count = cfg_data[3:0];
          REG_NACK_UNMATCHED: nack_unm = cfg_data[0];
          REG_NO_ROUTE:       noroute_code = cfg_data[7:0];
          REG_RNG_SEED:       rng_st = cfg_data;
          REG_RNG_STREAM:     rng_stream = cfg_data[62:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_item(item, has, r);
        if (has) pending_replies.push_back(typed_valid ? typed_res : r);
      end
      if ((start && !busy) || done || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("name_prefix_weighted_responder_top regression: fail");
        $finish;
      end
    end
  end

  function automatic item_t mk(cmd_t c, int sel, int slot, int val, bit lst,
                               logic [63:0] tok);
    item_t it;
    it.cmd = c;
    it.pattern_sel = 3'(sel);
    it.slot = 6'(slot);
    it.value = 10'(val);
    it.last = lst;
    it.token = tok;
    return it;
  endfunction

  function automatic result_t mk_res(bit m, int pi, int ri, act_t a, int code,
                                     logic [63:0] tok);
    result_t r;
    r.matched = m;
    r.pattern_index = 3'(pi);
    r.reply_index = 3'(ri);
    r.action = a;
    r.nack_code = 8'(code);
    r.token_out = tok;
    return r;
  endfunction

  task automatic send(input item_t it, input bit tv, input result_t tr);
    start <= 1'b1;
    item <= it;
    typed_valid <= tv;
    typed_res <= tr;
    sent++;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_rand(input item_t it);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    send(it, 1'b0, '0);
  endtask

  task automatic drain(input int extra);
    start <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic program_regs(input logic [3:0] pc, input logic nu, input logic [7:0] nr,
                              input logic [63:0] seed, input logic [62:0] strm);
    cfg_we <= 1'b1;
    cfg_index <= REG_PATTERN_COUNT;  cfg_data <= 64'(pc);   @(posedge clk);
    cfg_index <= REG_NACK_UNMATCHED; cfg_data <= 64'(nu);   @(posedge clk);
    cfg_index <= REG_NO_ROUTE;       cfg_data <= 64'(nr);   @(posedge clk);
    cfg_index <= REG_RNG_SEED;       cfg_data <= seed;      @(posedge clk);
    cfg_index <= REG_RNG_STREAM;     cfg_data <= 64'(strm); @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t rand_load();
    item_t it;
    it = mk(cmd_t'($urandom_range(0, 4)), $urandom_range(0, 7), $urandom_range(0, 63),
            $urandom_range(0, 1023), $urandom_range(0, 1), rand64());
    // keep prefix lengths and weight counts mostly short so names can match
    if ((it.cmd == CMD_PLEN || it.cmd == CMD_WCOUNT) && $urandom_range(0, 9) < 8)
      it.value = 10'($urandom_range(0, 5));
    // only the last pattern has every prefix byte loaded
    if (it.cmd == CMD_PLEN && it.pattern_sel != 3'(NPAT - 1) && it.value > PFX_FILL)
      it.value = 10'($urandom_range(0, PFX_FILL));
    if ($urandom_range(0, 49) == 0) it.cmd = 3'($urandom_range(6, 7));
    return it;
  endfunction

  // a name aimed at one pattern, sometimes with a corrupted byte
  task automatic send_name();
    int          p;
    int          n;
    int          bad;
    logic [7:0]  b;
    p = $urandom_range(0, NPAT - 1);
    n = plen_tbl[p] + $urandom_range(0, 3);
    if (n == 0) n = 1;
    if ($urandom_range(0, 29) == 0) n = $urandom_range(60, 70);
    bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
    for (int k = 0; k < n; k++) begin
      b = (k < plen_tbl[p] && k != bad) ? pfx_mem[p][k] : 8'($urandom);
      if ($urandom_range(0, 19) == 0) send_rand(rand_load());
      send_rand(mk(CMD_NAME, $urandom_range(0, 7), $urandom_range(0, 63),
                   {2'($urandom), b}, k == n - 1, rand64()));
    end
  endtask

  dir_row_t rows[$];

  initial begin
    logic [63:0] ones;
    ones = '1;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    typed_valid = 1'b0;
    typed_res = '0;
    errors = 0;
    sent = 0;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every entry a name can read gets written first; other patterns keep short prefixes
    for (int p = 0; p < NPAT; p++) begin
      for (int s = 0; s < ((p == NPAT - 1) ? NPFX : PFX_FILL); s++)
        send(mk(CMD_PREFIX, p, s, $urandom_range(0, 1023), 0, 0), 0, '0);
      for (int s = 0; s < NWGT; s++)
        send(mk(CMD_WEIGHT, p, s, $urandom_range(0, 1023), 0, 0), 0, '0);
      for (int s = 0; s < NREP; s++)
        send(mk(CMD_REPLY, p, s, $urandom_range(0, 1023), 0, 0), 0, '0);
    end
    drain(4);
    program_regs(4'd1, 1'b1, 8'd255, '0, '0);

    rows.push_back('{mk(CMD_PREFIX, 0, 0, 'h041, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_PREFIX, 0, 1, 'h042, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_PREFIX, 0, 63, 'h3FF, 1, ones), 0, '0});
    rows.push_back('{mk(CMD_PLEN, 0, 0, 2, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_WEIGHT, 0, 0, 'h3FB, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_WCOUNT, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_REPLY, 0, 3, 'h107, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_REPLY, 0, 63, 'h3FF, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_WEIGHT, 0, 63, 'h3FF, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_PLEN, 7, 63, 1023, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_WCOUNT, 7, 63, 1023, 0, 0), 0, '0});
    rows.push_back('{mk(cmd_t'(3'd6), 0, 0, 0, 1, 0), 0, '0});
    rows.push_back('{mk(cmd_t'(3'd7), 7, 63, 1023, 1, ones), 0, '0});
    // name shorter than the prefix
    rows.push_back('{mk(CMD_NAME, 0, 0, 'h041, 1, 0), 1, mk_res(0, 0, 0, ACT_NACK, 255, 0)});
    // upper value bits are ignored
    rows.push_back('{mk(CMD_NAME, 0, 0, 'h341, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_NAME, 0, 0, 'h042, 1, ones), 1,
                     mk_res(1, 0, 3, ACT_NACK, 7, ones)});
    rows.push_back('{mk(CMD_NAME, 0, 0, 'h041, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_NAME, 0, 0, 'h042, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_NAME, 0, 0, 'h0FF, 1, 64'h0123456789ABCDEF), 1,
                     mk_res(1, 0, 3, ACT_NACK, 7, 64'h0123456789ABCDEF)});
    rows.push_back('{mk(CMD_NAME, 0, 0, 'h041, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_NAME, 0, 0, 'h043, 1, 5), 1, mk_res(0, 0, 0, ACT_NACK, 255, 5)});
    // reply kind 3 drops
    rows.push_back('{mk(CMD_REPLY, 0, 3, 'h3AA, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_NAME, 0, 0, 'h041, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_NAME, 0, 0, 'h042, 1, 6), 1, mk_res(1, 0, 3, ACT_DROP, 0, 6)});
    rows.push_back('{mk(CMD_REPLY, 0, 3, 'h055, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_NAME, 0, 0, 'h041, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_NAME, 0, 0, 'h042, 1, 7), 1, mk_res(1, 0, 3, ACT_DATA, 0, 7)});
    foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);
    drain(60);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_regs(4'd8, 1'b1, 8'd255, '0, '0);
        1: program_regs(4'd15, 1'b0, 8'd0, ones, '1);
        2: program_regs(4'd0, 1'b1, 8'($urandom), rand64(), 63'(rand64()));
        default: program_regs(4'($urandom_range(0, 15)), 1'($urandom), 8'($urandom),
                              rand64(), 63'(rand64()));
      endcase
      case (ph % 4)
        0: idle_pct = 0;
        3: idle_pct = 24;
        default: idle_pct = 45;
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (ph == 3 && sent > PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 3)
          drain(0);
        if ($urandom_range(0, 9) < 6) send_name();
        else send_rand(rand_load());
      end
      drain(60);
    end

    if (errors == 0) begin
      $display("name_prefix_weighted_responder_top regression: pass");
    end else begin
      $display("name_prefix_weighted_responder_top regression: fail");
    end
    $finish;
  end

endmodule
